[hw/rtl/tape_pulse_stream_decoder_assert.svh]
// ----------------------------------------------------------------------------
// Tape pulse stream decoder assertion macros
// Short forms for the clocked assertions used in the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef TAPE_PULSE_STREAM_DECODER_ASSERT_SVH
`define TAPE_PULSE_STREAM_DECODER_ASSERT_SVH

// check on every edge once out of reset
`define TPSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every edge, reset included
`define TPSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/tpsd_pkg.sv]
// ----------------------------------------------------------------------------
// Tape pulse stream decoder package
// Shared types, signatures, clock table and result codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpsd_pkg;

    localparam int unsigned HEADER_BYTES_DEF = 20;
    localparam int unsigned SIG_LEN          = 12;
    localparam int unsigned POS_VERSION      = 12;
    localparam int unsigned POS_MACHINE      = 13;
    localparam int unsigned POS_VIDEO        = 14;

    localparam logic [7:0] SIG_A [SIG_LEN] = '{
        8'h43, 8'h36, 8'h34, 8'h2D, 8'h46, 8'h49,
        8'h4C, 8'h45, 8'h2D, 8'h52, 8'h41, 8'h57
    };
    localparam logic [7:0] SIG_B [SIG_LEN] = '{
        8'h43, 8'h31, 8'h36, 8'h2D, 8'h46, 8'h49,
        8'h4C, 8'h45, 8'h2D, 8'h52, 8'h41, 8'h57
    };

    localparam logic [1:0]  VERSION_SHORT  = 2'd0;
    localparam logic [1:0]  VERSION_HALF   = 2'd2;
    localparam logic [1:0]  MACHINE_LIMIT  = 2'd3;
    localparam logic [1:0]  LONG_BYTES     = 2'd3;
    localparam logic [20:0] SHORT_OVERFLOW = 21'h00100;
    localparam logic [23:0] LONG_OVERFLOW  = 24'hFFFFFF;

    typedef enum logic [1:0] {
        KIND_PULSE   = 2'd0,
        KIND_HDR_OK  = 2'd1,
        KIND_HDR_BAD = 2'd2
    } t_kind;

    typedef struct packed {
        logic        fin;
        logic        ok;
        logic [17:0] clock_rate;
        logic        half_waves;
    } t_hdr_res;

    typedef struct packed {
        logic       done;
        logic [1:0] version;
    } t_hdr_stat;

    function automatic logic [17:0] clock_lookup(input logic [1:0] machine, input logic video);
        logic [17:0] rate;
        unique case (machine)
            2'd0:    rate = video ? 18'd127840 : 18'd123156;
            2'd1:    rate = video ? 18'd127840 : 18'd138550;
            2'd2:    rate = video ? 18'd111860 : 18'd110840;
            default: rate = 18'd0;
        endcase
        return rate;
    endfunction

endpackage

[hw/rtl/tpsd_hdr.sv]
// ----------------------------------------------------------------------------
// Tape pulse stream decoder header parser
// Checks signature and format fields, one byte per step, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpsd_hdr
    import tpsd_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_hdr_res   o_res,
    output t_hdr_stat  o_stat
);

    localparam int unsigned     POS_W    = $clog2(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);

    logic             r_done,      n_done;
    logic [POS_W-1:0] r_pos,       n_pos;
    logic             r_sig_a,     n_sig_a;
    logic             r_sig_b,     n_sig_b;
    logic [1:0]       r_version,   n_version;
    logic [1:0]       r_machine,   n_machine;
    logic             r_video,     n_video;
    logic             r_fields_ok, n_fields_ok;
    logic             hdr_ok;

    always_comb begin
        n_done      = r_done;
        n_pos       = r_pos;
        n_sig_a     = r_sig_a;
        n_sig_b     = r_sig_b;
        n_version   = r_version;
        n_machine   = r_machine;
        n_video     = r_video;
        n_fields_ok = r_fields_ok;
        hdr_ok      = 1'b0;
        o_res       = '0;
        if (i_step && !r_done) begin
            if (r_pos < POS_W'(SIG_LEN)) begin
                if (i_byte != SIG_A[r_pos[3:0]]) n_sig_a = 1'b0;
                if (i_byte != SIG_B[r_pos[3:0]]) n_sig_b = 1'b0;
            end else if (r_pos == POS_W'(POS_VERSION)) begin
                n_version = i_byte[1:0];
                if (i_byte > 8'd2) n_fields_ok = 1'b0;
            end else if (r_pos == POS_W'(POS_MACHINE)) begin
                n_machine = i_byte[1:0];
                if (i_byte > 8'd2) n_fields_ok = 1'b0;
            end else if (r_pos == POS_W'(POS_VIDEO)) begin
                n_video = i_byte[0];
                if (i_byte > 8'd1) n_fields_ok = 1'b0;
            end
            if (r_pos != POS_LAST) begin
                n_pos = r_pos + 1'b1;
            end else begin
                hdr_ok    = (n_sig_a || n_sig_b) && n_fields_ok && (n_machine < MACHINE_LIMIT);
                o_res.fin = 1'b1;
                o_res.ok  = hdr_ok;
                n_pos     = '0;
                if (hdr_ok) begin
                    n_done           = 1'b1;
                    o_res.clock_rate = clock_lookup(n_machine, n_video);
                    o_res.half_waves = (n_version == VERSION_HALF);
                end else begin
                    n_sig_a     = 1'b1;
                    n_sig_b     = 1'b1;
                    n_version   = '0;
                    n_machine   = '0;
                    n_video     = 1'b0;
                    n_fields_ok = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b0;
            r_pos       <= '0;
            r_sig_a     <= 1'b1;
            r_sig_b     <= 1'b1;
            r_version   <= '0;
            r_machine   <= '0;
            r_video     <= 1'b0;
            r_fields_ok <= 1'b1;
        end else begin
            r_done      <= n_done;
            r_pos       <= n_pos;
            r_sig_a     <= n_sig_a;
            r_sig_b     <= n_sig_b;
            r_version   <= n_version;
            r_machine   <= n_machine;
            r_video     <= n_video;
            r_fields_ok <= n_fields_ok;
        end
    end

    assign o_stat.done    = r_done;
    assign o_stat.version = r_version;

endmodule

[hw/rtl/tape_pulse_stream_decoder.sv]
// ----------------------------------------------------------------------------
// Tape pulse stream decoder
// Parses a raw tape-image header, then turns pulse codes into pulse lengths.
//
//   channel  dir  valid        stall        payload
//   in       in   i_in_valid   o_in_stall   i_data_byte
//   out      out  o_out_valid  i_out_stall  o_result_kind, o_pulse_length,
//                                           o_clock_rate, o_half_waves
//
// One byte per cycle sustained while the output is not stalled.
// The byte register feeds a single decode step whose result lands in the
// output register; the overflow sum adder sets the longest path.
// Synchronous active-low reset; no clearing pass, ready once reset is released.
// A stalled output holds its word and stalls the input once the byte register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tape_pulse_stream_decoder
    import tpsd_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_pulse_length,
    output logic [17:0] o_clock_rate,
    output logic        o_half_waves
);

`include "tape_pulse_stream_decoder_assert.svh"

    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic [1:0]  r_long_cnt, n_long_cnt;
    logic [23:0] r_long_val, n_long_val;
    logic [31:0] r_sum,      n_sum;
    logic        r_out_valid, n_out_valid;
    t_kind       r_out_kind;
    logic [31:0] r_out_len;
    logic [17:0] r_out_rate;
    logic        r_out_half;

    logic        out_free;
    logic        in_accept;
    logic        step;
    logic        emit;
    logic        add_en;
    logic [20:0] add_val;
    logic [23:0] long_v;
    logic [32:0] sum_ext;
    logic [31:0] sum_sat;
    t_hdr_res    hdr_res;
    t_hdr_stat   hdr_stat;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign step       = r_in_valid && out_free;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (out_free) begin
            n_in_valid = 1'b0;
        end
    end

    tpsd_hdr #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_hdr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (hdr_res),
        .o_stat  (hdr_stat)
    );

    always_comb begin
        n_long_cnt = r_long_cnt;
        n_long_val = r_long_val;
        emit       = 1'b0;
        add_en     = 1'b0;
        add_val    = '0;
        long_v     = {r_in_byte, r_long_val[15:0]};
        if (step && hdr_stat.done) begin
            if (r_long_cnt != 2'd0) begin
                n_long_cnt = r_long_cnt - 2'd1;
                unique case (r_long_cnt)
                    2'd3:    n_long_val[7:0]  = r_in_byte;
                    2'd2:    n_long_val[15:8] = r_in_byte;
                    default: begin
                        n_long_val = '0;
                        add_en     = 1'b1;
                        add_val    = long_v[23:3];
                        emit       = (long_v != LONG_OVERFLOW);
                    end
                endcase
            end else if (r_in_byte == 8'd0) begin
                if (hdr_stat.version == VERSION_SHORT) begin
                    add_en  = 1'b1;
                    add_val = SHORT_OVERFLOW;
                end else begin
                    n_long_cnt = LONG_BYTES;
                    n_long_val = '0;
                end
            end else begin
                add_en  = 1'b1;
                add_val = {13'd0, r_in_byte};
                emit    = 1'b1;
            end
        end
    end

    assign sum_ext = {1'b0, r_sum} + {12'd0, add_val};
    assign sum_sat = sum_ext[32] ? '1 : sum_ext[31:0];

    always_comb begin
        n_sum = r_sum;
        if (add_en) n_sum = sum_sat;
        if (emit)   n_sum = '0;
        if (hdr_res.fin && hdr_res.ok) begin
            n_sum = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = step && (emit || hdr_res.fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_long_cnt  <= '0;
            r_long_val  <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_long_cnt  <= (hdr_res.fin && hdr_res.ok) ? 2'd0 : n_long_cnt;
            r_long_val  <= (hdr_res.fin && hdr_res.ok) ? 24'd0 : n_long_val;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
        end
        if (out_free && step && (emit || hdr_res.fin)) begin
            if (hdr_res.fin) begin
                r_out_kind <= hdr_res.ok ? KIND_HDR_OK : KIND_HDR_BAD;
                r_out_len  <= '0;
            end else begin
                r_out_kind <= KIND_PULSE;
                r_out_len  <= sum_sat;
            end
            r_out_rate <= hdr_res.clock_rate;
            r_out_half <= hdr_res.half_waves;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_pulse_length = r_out_len;
    assign o_clock_rate   = r_out_rate;
    assign o_half_waves   = r_out_half;

    `TPSD_ASSERT(a_long_after_hdr, (r_long_cnt != 2'd0) |-> hdr_stat.done, "long code before header")
    `TPSD_ASSERT(a_hdr_ok_done, (step && hdr_res.fin && hdr_res.ok) |=> hdr_stat.done, "header not latched")
    `TPSD_ASSERT(a_sum_cleared, (step && emit) |=> (r_sum == 32'd0), "sum not cleared after pulse")
    `TPSD_ASSERT_ALWAYS(a_pulse_plain, (r_out_valid && (r_out_kind == KIND_PULSE)) |-> ((r_out_rate == 18'd0) && !r_out_half), "pulse word carries header fields")

endmodule
